FILE: rtl/qph_pkg.sv
// Package for the quadratic probe hash table: field widths, codes and request type.
// No dependencies; qph_front, qph_back and the top unit use it by scoped names.
package qph_pkg;

  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  localparam logic [STATUS_W-1:0] RES_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] RES_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] RES_FULL      = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

endpackage

FILE: rtl/qph_fifo.sv
// Small register queue used between the front and the back and for results.
// Depends on nothing but its parameters.
module qph_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/qph_front.sv
// Front part: takes an item and finds its home slot, key mod table size, by a reciprocal
// multiplication and a conditional subtract. Depends on qph_pkg.
module qph_front #(
  parameter int TABLE_SIZE = 31,
  localparam int HomeW = $clog2(TABLE_SIZE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  qph_pkg::req_t     in_req,
  output logic              busy,
  output logic              out_push,
  output qph_pkg::req_t     out_req,
  output logic [HomeW-1:0]  out_home,
  input  logic              out_full
);

  localparam int ProdW = 2 * qph_pkg::KEY_W;
  localparam int DiffW = HomeW + 1;
  localparam logic [qph_pkg::KEY_W-1:0] Recip =
    qph_pkg::KEY_W'((64'd1 << qph_pkg::KEY_W) / TABLE_SIZE);

  logic [1:0]                cnt;
  logic [ProdW-1:0]          prod;
  logic [qph_pkg::KEY_W-1:0] quot;
  logic [DiffW-1:0]          diff;
  logic [HomeW-1:0]          rem;
  logic [HomeW-1:0]          rem_next;
  logic                      walking;

  // The quotient estimate is low by at most one, so one conditional subtract finishes.
  assign walking  = busy && (cnt != 2'd2);
  assign quot     = prod[ProdW-1:qph_pkg::KEY_W];
  assign diff     = DiffW'(out_req.key) - DiffW'(quot) * DiffW'(TABLE_SIZE);
  assign rem_next = (diff >= DiffW'(TABLE_SIZE)) ?
                    HomeW'(diff - DiffW'(TABLE_SIZE)) : HomeW'(diff);
  assign out_push = busy && !walking && !out_full;
  assign out_home = rem;

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_req <= in_req;
    end else if (walking && (cnt == 2'd0)) begin
      prod <= ProdW'(out_req.key) * ProdW'(Recip);
    end else if (walking) begin
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (walking) begin
      cnt <= cnt + 1'b1;
    end else if (out_push) begin
      busy <= 1'b0;
    end
  end

endmodule

FILE: rtl/qph_back.sv
// Back part: walks the quadratic probe sequence over the slot memories, one probe a cycle.
// Depends on qph_pkg; holds the status, key and value memories and the reset clearing pass.
module qph_back #(
  parameter int TABLE_SIZE = 31,
  localparam int HomeW = $clog2(TABLE_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst,
  output logic                            clearing,
  input  logic                            q_empty,
  output logic                            q_pop,
  input  qph_pkg::req_t                   q_req,
  input  logic [HomeW-1:0]                q_home,
  output logic                            res_push,
  output logic [qph_pkg::STATUS_W-1:0]    res_status,
  output logic [qph_pkg::SLOT_W-1:0]      res_slot,
  input  logic                            res_full
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]                slot_status [TABLE_SIZE];
  logic [qph_pkg::KEY_W-1:0] slot_key    [TABLE_SIZE];
  logic [qph_pkg::VAL_W-1:0] slot_value  [TABLE_SIZE];

  logic [HomeW-1:0]          pos;
  logic [HomeW-1:0]          inc;
  logic [HomeW-1:0]          step;
  logic [HomeW-1:0]          clr_idx;
  qph_pkg::req_t             req;
  logic [1:0]                rd_st;
  logic [qph_pkg::KEY_W-1:0] rd_key;

  logic [HomeW:0]            pos_sum;
  logic [HomeW:0]            inc_sum;
  logic [HomeW-1:0]          pos_next;
  logic [HomeW-1:0]          inc_next;
  logic [HomeW-1:0]          rd_addr;
  logic [HomeW-1:0]          wr_addr;
  logic                      wr_en;
  logic [1:0]                wr_st;
  logic                      ins_hit;
  logic                      rem_hit;
  logic                      rem_stop;
  logic                      last;
  logic                      done;

  assign pos_sum  = {1'b0, pos} + {1'b0, inc};
  assign pos_next = (pos_sum >= (HomeW + 1)'(TABLE_SIZE)) ?
                    HomeW'(pos_sum - (HomeW + 1)'(TABLE_SIZE)) : HomeW'(pos_sum);
  assign inc_sum  = {1'b0, inc} + (HomeW + 1)'(2);
  assign inc_next = (inc_sum >= (HomeW + 1)'(TABLE_SIZE)) ?
                    HomeW'(inc_sum - (HomeW + 1)'(TABLE_SIZE)) : HomeW'(inc_sum);

  assign ins_hit  = (req.kind == qph_pkg::KIND_INSERT) && (rd_st != qph_pkg::ST_USED);
  assign rem_hit  = (req.kind == qph_pkg::KIND_REMOVE) && (rd_st == qph_pkg::ST_USED) &&
                    (rd_key == req.key);
  assign rem_stop = (req.kind == qph_pkg::KIND_REMOVE) && (rd_st == qph_pkg::ST_EMPTY);
  assign last     = (step == HomeW'(TABLE_SIZE - 1));
  assign done     = ins_hit || rem_hit || rem_stop || last;

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty && !res_full;
  assign res_push = (state == S_PROBE) && done;

  always_comb begin
    if (ins_hit) begin
      res_status = qph_pkg::RES_INSERTED;
      res_slot   = qph_pkg::SLOT_W'(pos);
    end else if (rem_hit) begin
      res_status = qph_pkg::RES_REMOVED;
      res_slot   = qph_pkg::SLOT_W'(pos);
    end else begin
      res_status = (req.kind == qph_pkg::KIND_INSERT) ?
                   qph_pkg::RES_FULL : qph_pkg::RES_NOT_FOUND;
      res_slot   = '0;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = pos_next;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_st      = qph_pkg::ST_USED;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_st   = qph_pkg::ST_EMPTY;
        if (clr_idx == HomeW'(TABLE_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = q_home;
        if (q_pop) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        wr_en = ins_hit || rem_hit;
        wr_st = ins_hit ? qph_pkg::ST_USED : qph_pkg::ST_DELETED;
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_status[wr_addr] <= wr_st;
    end
    if ((state == S_PROBE) && ins_hit) begin
      slot_key[pos]   <= req.key;
      slot_value[pos] <= req.value;
    end
    rd_st  <= slot_status[rd_addr];
    rd_key <= slot_key[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req  <= q_req;
      pos  <= q_home;
      inc  <= HomeW'(1);
      step <= '0;
    end else if ((state == S_PROBE) && !done) begin
      pos  <= pos_next;
      inc  <= inc_next;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/quadratic_probe_hash_table_unit.sv
// From an accepted item to its result: the front reduces the key mod the table size by a
// reciprocal multiplication and a conditional subtract, then the back takes the item from
// the queue and makes P probes (1 to TABLE_SIZE) via the single read port of the slot memories.
// Front and back overlap through a queue: the front takes a new item once it has passed its last one on.
// Reset: a clearing pass marks every slot empty in turn; full stays high meanwhile.
module quadratic_probe_hash_table_unit #(
  parameter int TABLE_SIZE = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic [qph_pkg::KEY_W-1:0]    key,
  input  logic [qph_pkg::VAL_W-1:0]    value,
  output logic                         empty,
  input  logic                         pop,
  output logic [qph_pkg::STATUS_W-1:0] status,
  output logic [qph_pkg::SLOT_W-1:0]   slot
);

  localparam int HomeW = $clog2(TABLE_SIZE);
  localparam int ReqW  = $bits(qph_pkg::req_t);
  localparam int MidW  = ReqW + HomeW;
  localparam int ResW  = qph_pkg::STATUS_W + qph_pkg::SLOT_W;

  qph_pkg::req_t     in_req;
  qph_pkg::req_t     f_req;
  logic [HomeW-1:0]  f_home;
  logic              f_busy;
  logic              f_push;
  logic              mid_full;
  logic              mid_empty;
  logic              mid_pop;
  logic [MidW-1:0]   mid_dout;
  logic              clearing;
  logic              res_push;
  logic              res_full;
  logic [qph_pkg::STATUS_W-1:0] res_status;
  logic [qph_pkg::SLOT_W-1:0]   res_slot;
  logic [ResW-1:0]   res_dout;

  assign in_req = '{kind: kind, key: key, value: value};
  assign full   = f_busy || clearing;

  qph_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_take  (push && !full),
    .in_req   (in_req),
    .busy     (f_busy),
    .out_push (f_push),
    .out_req  (f_req),
    .out_home (f_home),
    .out_full (mid_full)
  );

  qph_fifo #(.WIDTH(MidW), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_req, f_home}),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  qph_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .q_empty    (mid_empty),
    .q_pop      (mid_pop),
    .q_req      (qph_pkg::req_t'(mid_dout[MidW-1:HomeW])),
    .q_home     (mid_dout[HomeW-1:0]),
    .res_push   (res_push),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_full   (res_full)
  );

  qph_fifo #(.WIDTH(ResW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   ({res_status, res_slot}),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign status = res_dout[ResW-1:qph_pkg::SLOT_W];
  assign slot   = res_dout[qph_pkg::SLOT_W-1:0];

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (rst) !(res_push && res_full))
    else $error("Result pushed into a full result queue.");

  a_mid_room: assert property (@(posedge clk) disable iff (rst) !(f_push && mid_full))
    else $error("Request pushed into a full middle queue.");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
      (!empty && (status == qph_pkg::RES_FULL || status == qph_pkg::RES_NOT_FOUND))
      |-> (slot == '0))
    else $error("A failed operation reports a nonzero slot.");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for quadratic_probe_hash_table_unit: directed and random inserts
// and removes, checked in order against a behavioral table kept alongside the block.
// Depends on rtl/qph_pkg.sv and rtl/quadratic_probe_hash_table_unit.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = 31;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [qph_pkg::STATUS_W-1:0] status;
    logic [qph_pkg::SLOT_W-1:0] slot;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic kind = qph_pkg::KIND_INSERT;
  logic [qph_pkg::KEY_W-1:0] key = '0;
  logic [qph_pkg::VAL_W-1:0] value = '0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [qph_pkg::STATUS_W-1:0] status;
  logic [qph_pkg::SLOT_W-1:0] slot;

  logic stall_hold = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  logic [1:0] tbl_state [TABLE_SIZE];
  logic [qph_pkg::KEY_W-1:0] tbl_key [TABLE_SIZE];
  table_reply_t pending_results[$];

  quadratic_probe_hash_table_unit #(
    .TABLE_SIZE(TABLE_SIZE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .kind(kind),
    .key(key),
    .value(value),
    .empty(empty),
    .pop(pop),
    .status(status),
    .slot(slot)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL quadratic_probe_hash_table_unit");
      $finish;
    end
  end

  function automatic void apply_table_op(logic op, logic [qph_pkg::KEY_W-1:0] k);
    int home;
    int s;
    table_reply_t r;
    home = int'(k % TABLE_SIZE);
    r.status = (op == qph_pkg::KIND_INSERT) ? qph_pkg::RES_FULL : qph_pkg::RES_NOT_FOUND;
    r.slot = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      s = (home + i * i) % TABLE_SIZE;
      if (op == qph_pkg::KIND_INSERT) begin
        if (tbl_state[s] != qph_pkg::ST_USED) begin
          tbl_state[s] = qph_pkg::ST_USED;
          tbl_key[s] = k;
          r.status = qph_pkg::RES_INSERTED;
          r.slot = qph_pkg::SLOT_W'(s);
          break;
        end
      end else begin
        if (tbl_state[s] == qph_pkg::ST_EMPTY) break;
        if (tbl_state[s] == qph_pkg::ST_USED && tbl_key[s] == k) begin
          tbl_state[s] = qph_pkg::ST_DELETED;
          r.status = qph_pkg::RES_REMOVED;
          r.slot = qph_pkg::SLOT_W'(s);
          break;
        end
      end
    end
    pending_results.push_back(r);
  endfunction

  function automatic bit pick_live_key(output logic [qph_pkg::KEY_W-1:0] k);
    int live[$];
    k = '0;
    foreach (tbl_state[s]) begin
      if (tbl_state[s] == qph_pkg::ST_USED) live.push_back(s);
    end
    if (live.size() == 0) return 1'b0;
    k = tbl_key[live[$urandom_range(0, live.size() - 1)]];
    return 1'b1;
  endfunction

  function automatic logic [qph_pkg::KEY_W-1:0] clustered_key(int home);
    logic [31:0] t;
    t = $urandom_range(0, 69273665) * TABLE_SIZE + home;
    return t[qph_pkg::KEY_W-1:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, status", status, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
      end
    end
  end

  task automatic send_item(logic op, logic [qph_pkg::KEY_W-1:0] k,
                           logic [qph_pkg::VAL_W-1:0] v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1'b1;
    kind <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (full);
    apply_table_op(op, k);
  endtask

  task automatic test_single_ops();
    send_item(qph_pkg::KIND_INSERT, '0, '0);
    send_item(qph_pkg::KIND_INSERT, '0, '1);
    send_item(qph_pkg::KIND_INSERT, '1, '1);
    send_item(qph_pkg::KIND_REMOVE, '1, '0);
    send_item(qph_pkg::KIND_REMOVE, '1, '1);
    send_item(qph_pkg::KIND_REMOVE, '0, 32'h5555_5555);
    send_item(qph_pkg::KIND_REMOVE, '0, 32'hAAAA_AAAA);
    send_item(qph_pkg::KIND_REMOVE, '0, '0);
    send_item(qph_pkg::KIND_REMOVE, qph_pkg::KEY_W'(5), '0);
  endtask

  task automatic test_collision_walk();
    logic [qph_pkg::KEY_W-1:0] victim;
    victim = '0;
    for (int i = 0; i < 17; i++) begin
      if (i == 7) victim = qph_pkg::KEY_W'(3 + i * TABLE_SIZE);
      send_item(qph_pkg::KIND_INSERT, qph_pkg::KEY_W'(3 + i * TABLE_SIZE), $urandom);
    end
    send_item(qph_pkg::KIND_REMOVE, victim, '0);
    send_item(qph_pkg::KIND_INSERT, clustered_key(3), $urandom);
    send_item(qph_pkg::KIND_REMOVE, clustered_key(3), $urandom);
  endtask

  task automatic test_random_ops(int count);
    int bias;
    int r;
    logic [qph_pkg::KEY_W-1:0] k;
    bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) bias = $urandom_range(25, 75);
      r = $urandom_range(99);
      if (r < bias) begin
        case ($urandom_range(3))
          0: k = qph_pkg::KEY_W'($urandom);
          3: if (!pick_live_key(k)) k = qph_pkg::KEY_W'($urandom);
          default: k = clustered_key($urandom_range(0, 3));
        endcase
        send_item(qph_pkg::KIND_INSERT, k, $urandom);
      end else if (r < 92) begin
        if (!pick_live_key(k)) k = clustered_key($urandom_range(0, 3));
        send_item(qph_pkg::KIND_REMOVE, k, $urandom);
      end else begin
        k = $urandom_range(1) ? qph_pkg::KEY_W'($urandom) : clustered_key($urandom_range(0, 3));
        send_item(qph_pkg::KIND_REMOVE, k, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
      end
    join_none
    test_random_ops(30);
  endtask

  initial begin
    foreach (tbl_state[s]) begin
      tbl_state[s] = qph_pkg::ST_EMPTY;
      tbl_key[s] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 52;
    test_single_ops();
    test_collision_walk();
    test_random_ops(650);

    send_idle_pct = 52;
    recv_idle_pct = 6;
    test_random_ops(650);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ops(650);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS quadratic_probe_hash_table_unit");
    end else begin
      $display("FAIL quadratic_probe_hash_table_unit");
    end
    $finish;
  end

endmodule

FILE: quadratic_probe_hash_table_unit.f
rtl/qph_pkg.sv
rtl/qph_fifo.sv
rtl/qph_front.sv
rtl/qph_back.sv
rtl/quadratic_probe_hash_table_unit.sv
verif/tb_top.sv
